[rtl/dtq_pkg.sv]
package dtq_pkg;

    localparam int DTQ_CAPACITY = 32;
    localparam int TIME_W       = 48;
    localparam int SLOT_W       = 5;
    localparam int TAG_W        = 8;
    localparam int KIND_W       = 3;
    localparam int CMD_W        = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ARMED     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STALE     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRED   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_TICK_DONE = 3'd5;

endpackage

[rtl/deadline_timer_queue.sv]
// Timer queue kept as a deadline-sorted list in a RAM with registered reads.
// Insert walks the list from the tail and cancel from the head, one entry at a time.
// A tick finds expired timers from the head, emits each one, then compacts the list.
// One command is in flight at a time; a finished result waits in the output register.
// Reset (aresetn low, synchronous) empties the queue and zeroes all slot tags;
// the list RAM needs no clearing pass.
module deadline_timer_queue
    import dtq_pkg::*;
#(
    parameter int CAPACITY = DTQ_CAPACITY
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [TIME_W-1:0]   s_time_value,
    input  logic [SLOT_W-1:0]   s_slot,
    input  logic [TAG_W-1:0]    s_tag,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [KIND_W-1:0]   m_kind,
    output logic [SLOT_W-1:0]   m_out_slot,
    output logic [TAG_W-1:0]    m_out_tag,
    output logic [TIME_W-1:0]   m_next_deadline,
    output logic                m_next_valid,
    output logic                m_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_INS   = 4'd1;
    localparam logic [3:0] ST_INSRD = 4'd2;
    localparam logic [3:0] ST_INSWR = 4'd3;
    localparam logic [3:0] ST_CAN   = 4'd4;
    localparam logic [3:0] ST_CANRD = 4'd5;
    localparam logic [3:0] ST_CANPR = 4'd6;
    localparam logic [3:0] ST_TKRD  = 4'd7;
    localparam logic [3:0] ST_TKCK  = 4'd8;
    localparam logic [3:0] ST_EMRD  = 4'd9;
    localparam logic [3:0] ST_EMOUT = 4'd10;
    localparam logic [3:0] ST_CPRD  = 4'd11;
    localparam logic [3:0] ST_CPWR  = 4'd12;
    localparam logic [3:0] ST_RES   = 4'd13;

    logic [3:0]         state_reg;
    logic [TIME_W-1:0]  tv_reg;
    logic [SLOT_W-1:0]  islot_reg;
    logic [TAG_W-1:0]   itag_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      n_reg;
    logic [CW-1:0]      count_reg;
    logic               found_reg;
    logic [TIME_W-1:0]  nd_reg;
    logic [TIME_W-1:0]  head_reg;
    logic [AW-1:0]      free_reg;
    logic [CAPACITY-1:0] busy_reg;
    logic [TAG_W-1:0]   tag_reg [CAPACITY];
    logic [KIND_W-1:0]  res_kind_reg;
    logic [SLOT_W-1:0]  res_slot_reg;
    logic [TAG_W-1:0]   res_tag_reg;

    logic [TIME_W-1:0]  sd_mem [CAPACITY];
    logic [AW-1:0]      ss_mem [CAPACITY];
    logic [TIME_W-1:0]  rd_sd;
    logic [AW-1:0]      rd_ss;

    logic [AW-1:0]      ra;
    logic [AW-1:0]      wa;
    logic               we;
    logic [TIME_W-1:0]  wd_sd;
    logic [AW-1:0]      wd_ss;

    logic [AW-1:0]      ta;
    logic               t_busy;
    logic [TAG_W-1:0]   t_tag;
    logic               free_found;
    logic [AW-1:0]      free_idx;
    logic [AW-1:0]      islot_idx;
    logic               islot_ok;
    logic               out_free;
    logic [CW-1:0]      idx_m1;
    logic [CW-1:0]      post_count;

    assign out_free   = !m_valid || m_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign islot_idx  = AW'(islot_reg);
    assign islot_ok   = (32'(islot_reg) < CAPACITY);
    assign idx_m1     = idx_reg - CW'(1);
    assign post_count = count_reg - n_reg;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    always_comb begin
        case (state_reg) inside
            ST_INS, ST_INSRD, ST_INSWR: ta = free_reg;
            ST_EMOUT:                   ta = rd_ss;
            default:                    ta = islot_idx;
        endcase
    end
    assign t_busy = busy_reg[ta];
    assign t_tag  = tag_reg[ta];

    always_comb begin
        ra    = idx_reg[AW-1:0];
        we    = 1'b0;
        wa    = idx_reg[AW-1:0];
        wd_sd = rd_sd;
        wd_ss = rd_ss;
        unique case (state_reg)
            ST_INSRD: begin
                ra = idx_m1[AW-1:0];
                if (idx_reg == '0) begin
                    we    = 1'b1;
                    wd_sd = tv_reg;
                    wd_ss = free_reg;
                end
            end
            ST_INSWR: begin
                ra = idx_m1[AW-1:0];
                we = 1'b1;
                if (rd_sd <= tv_reg) begin
                    wd_sd = tv_reg;
                    wd_ss = free_reg;
                end
            end
            ST_CANPR: begin
                wa = idx_m1[AW-1:0];
                we = found_reg;
            end
            ST_CPWR: begin
                wa = AW'(idx_reg - n_reg);
                we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            sd_mem[wa] <= wd_sd;
            ss_mem[wa] <= wd_ss;
        end
        rd_sd <= sd_mem[ra];
        rd_ss <= ss_mem[ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            busy_reg  <= '0;
            m_valid   <= 1'b0;
            for (int i = 0; i < CAPACITY; i++) tag_reg[i] <= '0;
        end else begin
            if (m_valid && m_ready && state_reg != ST_EMOUT && state_reg != ST_RES)
                m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        tv_reg    <= s_time_value;
                        islot_reg <= s_slot;
                        itag_reg  <= s_tag;
                        idx_reg   <= '0;
                        n_reg     <= '0;
                        found_reg <= 1'b0;
                        case (s_cmd)
                            CMD_INSERT: state_reg <= ST_INS;
                            CMD_CANCEL: state_reg <= ST_CAN;
                            CMD_TICK:   state_reg <= ST_TKRD;
                            default: begin
                                res_kind_reg <= KIND_TICK_DONE;
                                res_slot_reg <= '0;
                                res_tag_reg  <= '0;
                                state_reg    <= ST_RES;
                            end
                        endcase
                    end
                end
                ST_INS: begin
                    if (32'(count_reg) >= CAPACITY || !free_found) begin
                        res_kind_reg <= KIND_FULL;
                        res_slot_reg <= '0;
                        res_tag_reg  <= '0;
                        state_reg    <= ST_RES;
                    end else begin
                        free_reg  <= free_idx;
                        idx_reg   <= count_reg;
                        state_reg <= ST_INSRD;
                    end
                end
                ST_INSRD: begin
                    if (idx_reg == '0) begin
                        head_reg  <= tv_reg;
                        state_reg <= ST_RES;
                    end else begin
                        state_reg <= ST_INSWR;
                    end
                end
                ST_INSWR: begin
                    if (rd_sd > tv_reg) begin
                        idx_reg   <= idx_m1;
                        state_reg <= ST_INSRD;
                    end else begin
                        state_reg <= ST_RES;
                    end
                end
                ST_CAN: begin
                    if (islot_ok && t_busy && t_tag == itag_reg) begin
                        state_reg <= ST_CANRD;
                    end else begin
                        res_kind_reg <= KIND_STALE;
                        res_slot_reg <= islot_reg;
                        res_tag_reg  <= itag_reg;
                        state_reg    <= ST_RES;
                    end
                end
                ST_CANRD: begin
                    if (idx_reg == count_reg) begin
                        count_reg           <= count_reg - CW'(1);
                        busy_reg[islot_idx] <= 1'b0;
                        tag_reg[islot_idx]  <= t_tag + TAG_W'(1);
                        res_kind_reg        <= KIND_CANCELLED;
                        res_slot_reg        <= islot_reg;
                        res_tag_reg         <= itag_reg;
                        state_reg           <= ST_RES;
                    end else begin
                        state_reg <= ST_CANPR;
                    end
                end
                ST_CANPR: begin
                    if (found_reg) begin
                        if (idx_m1 == '0) head_reg <= rd_sd;
                    end else if (rd_ss == islot_idx) begin
                        found_reg <= 1'b1;
                    end
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= ST_CANRD;
                end
                ST_TKRD: begin
                    if (idx_reg == count_reg) begin
                        n_reg     <= idx_reg;
                        idx_reg   <= '0;
                        state_reg <= ST_EMRD;
                    end else begin
                        state_reg <= ST_TKCK;
                    end
                end
                ST_TKCK: begin
                    if (rd_sd <= tv_reg) begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= ST_TKRD;
                    end else begin
                        n_reg     <= idx_reg;
                        nd_reg    <= rd_sd;
                        idx_reg   <= '0;
                        state_reg <= ST_EMRD;
                    end
                end
                ST_EMRD: begin
                    state_reg <= (idx_reg == n_reg) ? ST_CPRD : ST_EMOUT;
                end
                ST_EMOUT: begin
                    if (out_free) begin
                        m_valid         <= 1'b1;
                        m_kind          <= KIND_EXPIRED;
                        m_out_slot      <= SLOT_W'(rd_ss);
                        m_out_tag       <= t_tag;
                        m_next_valid    <= (post_count != '0);
                        m_next_deadline <= (post_count != '0) ? nd_reg : '0;
                        m_last          <= 1'b0;
                        busy_reg[ta]    <= 1'b0;
                        tag_reg[ta]     <= t_tag + TAG_W'(1);
                        idx_reg         <= idx_reg + CW'(1);
                        state_reg       <= ST_EMRD;
                    end
                end
                ST_CPRD: begin
                    if (idx_reg == count_reg) begin
                        count_reg    <= post_count;
                        head_reg     <= nd_reg;
                        res_kind_reg <= KIND_TICK_DONE;
                        res_slot_reg <= '0;
                        res_tag_reg  <= '0;
                        state_reg    <= ST_RES;
                    end else begin
                        state_reg <= ST_CPWR;
                    end
                end
                ST_CPWR: begin
                    idx_reg   <= idx_reg + CW'(1);
                    state_reg <= ST_CPRD;
                end
                ST_RES: begin
                    if (out_free) begin
                        m_valid         <= 1'b1;
                        m_kind          <= res_kind_reg;
                        m_out_slot      <= res_slot_reg;
                        m_out_tag       <= res_tag_reg;
                        m_next_valid    <= (count_reg != '0);
                        m_next_deadline <= (count_reg != '0) ? head_reg : '0;
                        m_last          <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if ((state_reg == ST_INSRD && idx_reg == '0) ||
                (state_reg == ST_INSWR && rd_sd <= tv_reg)) begin
                count_reg         <= count_reg + CW'(1);
                busy_reg[free_reg] <= 1'b1;
                res_kind_reg      <= KIND_ARMED;
                res_slot_reg      <= SLOT_W'(free_reg);
                res_tag_reg       <= t_tag;
            end
        end
    end

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CAPACITY)
        else $error("pending count above capacity");
    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> $countones(busy_reg) == 32'(count_reg))
        else $error("busy slots disagree with pending count");
    a_expired_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_EXPIRED |-> !m_last)
        else $error("expired result marked last");
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_TICK_DONE |-> m_last)
        else $error("tick done not marked last");
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted command not started");
`endif

endmodule

[tb/sv/deadline_timer_queue_test.sv]
`timescale 1ns / 1ps

module deadline_timer_queue_test;
    import dtq_pkg::*;

    localparam int CAP = DTQ_CAPACITY;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] tv;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        bit                live;
        bit                drain;
        int                phase;
    } timer_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [TAG_W-1:0]  tag;
        logic [TIME_W-1:0] next_deadline;
        logic              next_valid;
        logic              last;
    } timer_event_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CMD_W-1:0] s_cmd = '0;
    logic [TIME_W-1:0] s_time_value = '0;
    logic [SLOT_W-1:0] s_slot = '0;
    logic [TAG_W-1:0] s_tag = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [KIND_W-1:0] m_kind;
    logic [SLOT_W-1:0] m_out_slot;
    logic [TAG_W-1:0] m_out_tag;
    logic [TIME_W-1:0] m_next_deadline;
    logic m_next_valid;
    logic m_last;

    deadline_timer_queue dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_time_value(s_time_value), .s_slot(s_slot), .s_tag(s_tag),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind),
        .m_out_slot(m_out_slot), .m_out_tag(m_out_tag),
        .m_next_deadline(m_next_deadline), .m_next_valid(m_next_valid),
        .m_last(m_last)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    timer_req_t   pending_reqs[$];
    timer_event_t expected_events[$];
    int errors = 0;
    int phase = 0;
    int idle_cycles = 0;

    // shadow timer state
    logic [TIME_W-1:0] list_deadline[CAP];
    logic [SLOT_W-1:0] list_slot[CAP];
    bit                slot_armed[CAP];
    logic [TAG_W-1:0]  slot_gen[CAP];
    int                armed_count = 0;

    function automatic timer_event_t make_event(logic [KIND_W-1:0] kind,
            logic [SLOT_W-1:0] slot, logic [TAG_W-1:0] tag, logic last);
        timer_event_t ev;
        ev.kind = kind;
        ev.slot = slot;
        ev.tag = tag;
        ev.next_deadline = armed_count != 0 ? list_deadline[0] : '0;
        ev.next_valid = armed_count != 0;
        ev.last = last;
        return ev;
    endfunction

    task automatic post_event(timer_event_t ev);
        expected_events.insert(expected_events.size(), ev);
    endtask

    task automatic queue_req(timer_req_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    task automatic drop_entry(int pos);
        for (int i = pos; i + 1 < armed_count; i++) begin
            list_deadline[i] = list_deadline[i+1];
            list_slot[i] = list_slot[i+1];
        end
        armed_count--;
    endtask

    task automatic queue_timer_events(timer_req_t r);
        int free_slot;
        int pos;
        int n;
        logic [SLOT_W-1:0] fired_slot[CAP];
        logic [TAG_W-1:0]  fired_tag[CAP];
        free_slot = -1;
        pos = 0;
        n = 0;
        case (r.cmd)
            CMD_INSERT: begin
                for (int i = CAP - 1; i >= 0; i--)
                    if (!slot_armed[i]) free_slot = i;
                if (armed_count >= CAP || free_slot < 0) begin
                    post_event(make_event(KIND_FULL, '0, '0, 1'b1));
                end else begin
                    while (pos < armed_count && list_deadline[pos] <= r.tv) pos++;
                    for (int i = armed_count; i > pos; i--) begin
                        list_deadline[i] = list_deadline[i-1];
                        list_slot[i] = list_slot[i-1];
                    end
                    list_deadline[pos] = r.tv;
                    list_slot[pos] = SLOT_W'(free_slot);
                    armed_count++;
                    slot_armed[free_slot] = 1'b1;
                    post_event(make_event(KIND_ARMED, SLOT_W'(free_slot),
                        slot_gen[free_slot], 1'b1));
                end
            end
            CMD_CANCEL: begin
                if (slot_armed[r.slot] && slot_gen[r.slot] == r.tag) begin
                    for (int i = 0; i < armed_count; i++)
                        if (list_slot[i] == r.slot) begin
                            drop_entry(i);
                            break;
                        end
                    slot_armed[r.slot] = 1'b0;
                    slot_gen[r.slot] = slot_gen[r.slot] + 1'b1;
                    post_event(make_event(KIND_CANCELLED, r.slot, r.tag, 1'b1));
                end else begin
                    post_event(make_event(KIND_STALE, r.slot, r.tag, 1'b1));
                end
            end
            CMD_TICK: begin
                while (armed_count > 0 && list_deadline[0] <= r.tv) begin
                    fired_slot[n] = list_slot[0];
                    drop_entry(0);
                    fired_tag[n] = slot_gen[fired_slot[n]];
                    slot_armed[fired_slot[n]] = 1'b0;
                    slot_gen[fired_slot[n]] = slot_gen[fired_slot[n]] + 1'b1;
                    n++;
                end
                for (int k = 0; k < n; k++)
                    post_event(make_event(KIND_EXPIRED, fired_slot[k],
                        fired_tag[k], 1'b0));
                post_event(make_event(KIND_TICK_DONE, '0, '0, 1'b1));
            end
            default: post_event(make_event(KIND_TICK_DONE, '0, '0, 1'b1));
        endcase
    endtask

    function automatic int sender_idle_pct(int p);
        return p == 0 ? 28 : (p == 1 ? 48 : 0);
    endfunction

    function automatic int receiver_idle_pct(int p);
        return p == 0 ? 48 : (p == 1 ? 28 : 0);
    endfunction

    // driver
    always @(posedge aclk) begin
        timer_req_t r;
        int pick;
        int live_slots[$];
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                r.cmd = s_cmd;
                r.tv = s_time_value;
                r.slot = s_slot;
                r.tag = s_tag;
                queue_timer_events(r);
            end
            if (s_valid && !s_ready) begin
                s_valid <= 1'b1;
            end else if (pending_reqs.size() == 0) begin
                s_valid <= 1'b0;
            end else if (pending_reqs[0].drain) begin
                s_valid <= 1'b0;
                if (expected_events.size() == 0 && !(s_valid && s_ready))
                    void'(pending_reqs.pop_front());
            end else if ($urandom_range(99) < sender_idle_pct(pending_reqs[0].phase)) begin
                s_valid <= 1'b0;
            end else begin
                r = pending_reqs.pop_front();
                phase <= r.phase;
                if (r.live) begin
                    live_slots.delete();
                    for (int i = 0; i < CAP; i++)
                        if (slot_armed[i]) live_slots.insert(live_slots.size(), i);
                    if (live_slots.size() != 0) begin
                        pick = live_slots[$urandom_range(live_slots.size() - 1)];
                        r.slot = SLOT_W'(pick);
                        r.tag = slot_gen[pick];
                        if ($urandom_range(7) == 0) r.tag = r.tag + 1'b1;
                    end
                end
                s_cmd <= r.cmd;
                s_time_value <= r.tv;
                s_slot <= r.slot;
                s_tag <= r.tag;
                s_valid <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        timer_event_t got;
        timer_event_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_out_slot, m_out_tag, m_next_deadline, m_next_valid, m_last};
                if (expected_events.size() == 0) begin
                    $display("%0t unexpected transfer kind=%0d slot=%0d tag=%0d", $realtime,
                        m_kind, m_out_slot, m_out_tag);
                    errors++;
                end else begin
                    want = expected_events.pop_front();
                    if (got !== want) begin
                        $display("%0t mismatch exp kind=%0d slot=%0d tag=%0d nd=%0d nv=%0d last=%0d",
                            $realtime, want.kind, want.slot, want.tag, want.next_deadline,
                            want.next_valid, want.last);
                        $display("%0t          got kind=%0d slot=%0d tag=%0d nd=%0d nv=%0d last=%0d",
                            $realtime, got.kind, got.slot, got.tag, got.next_deadline,
                            got.next_valid, got.last);
                        errors++;
                    end
                end
            end
            m_ready <= $urandom_range(99) >= receiver_idle_pct(phase);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("deadline_timer_queue regression: fail");
                $finish;
            end
        end
    end

    task automatic add_req(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] tv,
            logic [SLOT_W-1:0] slot, logic [TAG_W-1:0] tag, int live, int p);
        timer_req_t r;
        r.cmd = cmd;
        r.tv = tv;
        r.slot = slot;
        r.tag = tag;
        r.live = (live != 0);
        r.drain = 1'b0;
        r.phase = p;
        queue_req(r);
    endtask

    task automatic add_drain(int p);
        timer_req_t r;
        r = '{cmd: CMD_TICK, tv: '0, slot: '0, tag: '0, live: 1'b0, drain: 1'b1, phase: p};
        queue_req(r);
    endtask

    function automatic logic [TIME_W-1:0] rand_time48();
        return TIME_W'({$urandom, $urandom});
    endfunction

    initial begin
        int sel;
        for (int i = 0; i < CAP; i++) begin
            slot_armed[i] = 1'b0;
            slot_gen[i] = '0;
        end
        // directed
        add_req(CMD_TICK, '0, '0, '0, 0, 0);
        add_req(CMD_INSERT, '0, '0, '0, 0, 0);
        add_req(CMD_INSERT, TIME_MAX, '0, '0, 0, 0);
        add_req(CMD_INSERT, 48'd5, '0, '0, 0, 0);
        add_req(CMD_INSERT, 48'd5, '0, '0, 0, 0);
        add_req(CMD_INSERT, 48'd9, '0, '0, 0, 0);
        add_req(CMD_CANCEL, '0, 5'd3, 8'd0, 0, 0);
        add_req(CMD_CANCEL, '0, 5'd3, 8'd0, 0, 0);
        add_req(CMD_CANCEL, '0, 5'd31, 8'd255, 0, 0);
        add_req(CMD_CANCEL, '0, 5'd1, 8'd7, 0, 0);
        add_req(CMD_INSERT, 48'd5, '0, '0, 0, 0);
        add_req(CMD_TICK, 48'd4, '0, '0, 0, 0);
        add_req(CMD_TICK, 48'd5, '0, '0, 0, 0);
        add_req(CMD_UNKNOWN, TIME_MAX, 5'd31, 8'd255, 0, 0);
        add_req(CMD_TICK, TIME_MAX, '0, '0, 0, 0);
        add_req(CMD_CANCEL, '0, 5'd0, 8'd0, 0, 0);
        add_req(CMD_TICK, TIME_MAX, '0, '0, 0, 0);
        add_drain(0);
        for (int p = 0; p < 3; p++) begin
            for (int n = 0; n < 75; n++) begin
                sel = $urandom_range(99);
                if (sel < 3) begin
                    // fill past capacity, then expire everything
                    for (int k = 0; k < CAP + 2; k++)
                        add_req(CMD_INSERT, 48'd1000 + $urandom_range(300), '0, '0, 0, p);
                    add_req(CMD_TICK, TIME_MAX, '0, '0, 0, p);
                end else if (sel < 45) begin
                    add_req(CMD_INSERT, $urandom_range(9) == 0 ? rand_time48()
                        : TIME_W'($urandom_range(600)), 5'($urandom), 8'($urandom), 0, p);
                end else if (sel < 65) begin
                    add_req(CMD_CANCEL, rand_time48(), 5'($urandom), 8'($urandom), 1, p);
                end else if (sel < 75) begin
                    add_req(CMD_CANCEL, rand_time48(), 5'($urandom), 8'($urandom), 0, p);
                end else if (sel < 97) begin
                    add_req(CMD_TICK, $urandom_range(15) == 0 ? TIME_MAX
                        : TIME_W'($urandom_range(600)), 5'($urandom), 8'($urandom), 0, p);
                end else begin
                    add_req(CMD_UNKNOWN, rand_time48(), 5'($urandom), 8'($urandom), 0, p);
                end
                if (n == 37) add_drain(p);
            end
            add_drain(p);
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_reqs.size() == 0 && !s_valid && expected_events.size() == 0);
        repeat (300) @(posedge aclk);
        if (errors == 0 && expected_events.size() == 0) begin
            $display("deadline_timer_queue regression: pass");
        end else begin
            $display("deadline_timer_queue regression: fail");
        end
        $finish;
    end
endmodule
